// ===== design/scc_pkg.sv =====
`default_nettype none

package scc_pkg;

    localparam int VERTEX_W = 5;
    localparam int COMP_W   = 5;
    localparam int CFG_W    = 6;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_F_SCAN,
        ST_F_WALK,
        ST_R_SCAN,
        ST_R_WALK
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store_arc;
        logic init;
        logic scan_adv;
        logic root;
        logic walk_step;
        logic comp_inc;
        logic rev_setup;
        logic clear_rows;
        logic reverse;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic scan_visited;
        logic depth_zero;
        logic cand_found;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== design/scc_ctrl.sv =====
`default_nettype none

module scc_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          last_arc,
    input  wire scc_pkg::sts_t sts,
    output scc_pkg::cmd_t      cmd,
    output logic               in_stall
);
    import scc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid && last_arc)
                begin
                    state_next = ST_F_SCAN;
                end
            end
            ST_F_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = ST_R_SCAN;
                end
                else if (!sts.scan_visited)
                begin
                    state_next = ST_F_WALK;
                end
            end
            ST_F_WALK:
            begin
                if (sts.depth_zero)
                begin
                    state_next = ST_F_SCAN;
                end
            end
            ST_R_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = ST_LOAD;
                end
                else if (!sts.scan_visited && sts.out_free)
                begin
                    state_next = ST_R_WALK;
                end
            end
            ST_R_WALK:
            begin
                if (sts.depth_zero)
                begin
                    state_next = ST_R_SCAN;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_LOAD:
            begin
                in_stall      = 1'b0;
                cmd.store_arc = in_valid;
                cmd.init      = in_valid && last_arc;
            end
            ST_F_SCAN:
            begin
                if (sts.scan_done)
                begin
                    cmd.rev_setup = 1'b1;
                end
                else if (sts.scan_visited)
                begin
                    cmd.scan_adv = 1'b1;
                end
                else
                begin
                    cmd.scan_adv = 1'b1;
                    cmd.root     = 1'b1;
                end
            end
            ST_F_WALK:
            begin
                cmd.walk_step = !sts.depth_zero;
            end
            ST_R_SCAN:
            begin
                cmd.reverse = 1'b1;
                if (sts.scan_done)
                begin
                    cmd.clear_rows = 1'b1;
                end
                else if (sts.scan_visited)
                begin
                    cmd.scan_adv = 1'b1;
                end
                else if (sts.out_free)
                begin
                    cmd.scan_adv = 1'b1;
                    cmd.root     = 1'b1;
                end
            end
            ST_R_WALK:
            begin
                cmd.reverse = 1'b1;
                if (sts.depth_zero)
                begin
                    cmd.comp_inc = 1'b1;
                end
                else if (!sts.cand_found || sts.out_free)
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/scc_datapath.sv =====
`default_nettype none

module scc_datapath #(
    parameter int MAX_VERTICES = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [scc_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic [scc_pkg::VERTEX_W-1:0]  tail_vertex,
    input  wire logic [scc_pkg::VERTEX_W-1:0]  head_vertex,
    input  wire logic                          arc_present,
    input  wire scc_pkg::cmd_t                 cmd,
    output scc_pkg::sts_t                      sts,
    input  wire logic                          out_stall,
    output logic                               out_valid,
    output logic [scc_pkg::VERTEX_W-1:0]       vertex_id,
    output logic [scc_pkg::COMP_W-1:0]         component_id,
    output logic                               last_result
);
    import scc_pkg::*;

    localparam int VL = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
    localparam int VW = $clog2(VL);
    localparam int DW = $clog2(VL + 1);

    logic [CFG_W-1:0]    vcount_reg;
    logic [DW-1:0]       n_eff;
    logic [VL-1:0]       nmask;

    logic [VL-1:0]       fwd_rows_reg [VL];
    logic [VL-1:0]       rev_rows_reg [VL];
    logic [VL-1:0]       visited_reg;
    logic [VW-1:0]       stack_reg [VL];
    logic [DW-1:0]       depth_reg;
    logic [VW-1:0]       finish_reg [VL];
    logic [DW-1:0]       fcount_reg;
    logic [DW-1:0]       idx_reg;
    logic [COMP_W-1:0]   comp_reg;
    logic [DW-1:0]       emit_cnt_reg;

    logic                out_valid_reg;
    logic [VERTEX_W-1:0] out_vertex_reg;
    logic [COMP_W-1:0]   out_comp_reg;
    logic                out_last_reg;

    logic [DW-1:0]       depth_m1;
    logic [DW-1:0]       idx_m1;
    logic [VW-1:0]       top_v;
    logic [VW-1:0]       scan_v;
    logic [VL-1:0]       cand;
    logic [VW-1:0]       low_v;
    logic                found;
    logic                arc_ok;
    logic                emit;
    logic [VW-1:0]       emit_v;
    logic                out_free;

    // Effective vertex count and the mask of live vertices.
    always_comb
    begin
        if (vcount_reg > CFG_W'(VL))
        begin
            n_eff = DW'(VL);
        end
        else
        begin
            n_eff = vcount_reg[DW-1:0];
        end
        for (int i = 0; i < VL; i++)
        begin
            nmask[i] = (DW'(i) < n_eff);
        end
    end

    assign depth_m1 = depth_reg - 1'b1;
    assign idx_m1   = idx_reg - 1'b1;
    assign top_v    = stack_reg[depth_m1[VW-1:0]];
    assign scan_v   = cmd.reverse ? finish_reg[idx_m1[VW-1:0]] : idx_reg[VW-1:0];

    assign cand = (cmd.reverse ? rev_rows_reg[top_v] : fwd_rows_reg[top_v])
                  & nmask & ~visited_reg;

    // Lowest set candidate wins.
    always_comb
    begin
        low_v = '0;
        found = 1'b0;
        for (int i = VL - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                low_v = VW'(i);
                found = 1'b1;
            end
        end
    end

    assign arc_ok = arc_present
                    && (CFG_W'(tail_vertex) < CFG_W'(n_eff))
                    && (CFG_W'(head_vertex) < CFG_W'(n_eff));

    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = cmd.reverse && (cmd.root || (cmd.walk_step && found));
    assign emit_v   = cmd.root ? scan_v : low_v;

    always_comb
    begin
        sts.scan_done    = cmd.reverse ? (idx_reg == '0) : (idx_reg == n_eff);
        sts.scan_visited = visited_reg[scan_v];
        sts.depth_zero   = (depth_reg == '0);
        sts.cand_found   = found;
        sts.out_free     = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= CFG_W'(32);
        end
        else if (cfg_we)
        begin
            vcount_reg <= cfg_data;
        end
    end

    // Adjacency matrices: one bit pair set per stored arc, wiped after a run.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < VL; r++)
            begin
                fwd_rows_reg[r] <= '0;
                rev_rows_reg[r] <= '0;
            end
        end
        else if (cmd.clear_rows)
        begin
            for (int r = 0; r < VL; r++)
            begin
                fwd_rows_reg[r] <= '0;
                rev_rows_reg[r] <= '0;
            end
        end
        else if (cmd.store_arc && arc_ok)
        begin
            fwd_rows_reg[tail_vertex[VW-1:0]][head_vertex[VW-1:0]] <= 1'b1;
            rev_rows_reg[head_vertex[VW-1:0]][tail_vertex[VW-1:0]] <= 1'b1;
        end
    end

    // Traversal control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg  <= '0;
            depth_reg    <= '0;
            fcount_reg   <= '0;
            idx_reg      <= '0;
            comp_reg     <= '0;
            emit_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.init)
            begin
                visited_reg  <= '0;
                depth_reg    <= '0;
                fcount_reg   <= '0;
                idx_reg      <= '0;
                comp_reg     <= '0;
                emit_cnt_reg <= '0;
            end
            else if (cmd.rev_setup)
            begin
                visited_reg <= '0;
                idx_reg     <= n_eff;
            end
            else
            begin
                if (cmd.scan_adv)
                begin
                    idx_reg <= cmd.reverse ? idx_m1 : idx_reg + 1'b1;
                end
                if (cmd.root)
                begin
                    visited_reg[scan_v] <= 1'b1;
                    depth_reg           <= DW'(1);
                end
                else if (cmd.walk_step)
                begin
                    if (found)
                    begin
                        visited_reg[low_v] <= 1'b1;
                        depth_reg          <= depth_reg + 1'b1;
                    end
                    else
                    begin
                        depth_reg <= depth_m1;
                        if (!cmd.reverse)
                        begin
                            fcount_reg <= fcount_reg + 1'b1;
                        end
                    end
                end
                if (cmd.comp_inc)
                begin
                    comp_reg <= comp_reg + 1'b1;
                end
                if (emit)
                begin
                    emit_cnt_reg <= emit_cnt_reg + 1'b1;
                end
            end
        end
    end

    // Walk stack and finish order; every entry is written before it is read.
    always_ff @(posedge clk)
    begin
        if (cmd.root)
        begin
            stack_reg[0] <= scan_v;
        end
        else if (cmd.walk_step && found)
        begin
            stack_reg[depth_reg[VW-1:0]] <= low_v;
        end
        if (cmd.walk_step && !found && !cmd.reverse)
        begin
            finish_reg[fcount_reg[VW-1:0]] <= top_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_vertex_reg <= VERTEX_W'(emit_v);
            out_comp_reg   <= comp_reg;
            out_last_reg   <= (emit_cnt_reg == n_eff - 1'b1);
        end
    end

    assign out_valid    = out_valid_reg;
    assign vertex_id    = out_vertex_reg;
    assign component_id = out_comp_reg;
    assign last_result  = out_last_reg;

endmodule

`default_nettype wire

// ===== design/strongly_connected_components.sv =====
// Arc loading: one arc beat per cycle, stored into both bit matrices at once.
// Run: starts the cycle after the last_arc beat; a forward and a reverse depth-first pass
// follow, one scan or stack step per cycle through the single neighbour-search unit, and
// the reverse pass holds any step that would emit a result while a stalled beat is pending.
// Throughput: one result beat at most per cycle; no new arc is taken until the run ends.
// Reset (rst_n, asynchronous, active low) clears matrices and traversal state; vertex_count 32.
`default_nettype none

module strongly_connected_components #(
    parameter int MAX_VERTICES = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [scc_pkg::CFG_W-1:0]     vertex_count,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [scc_pkg::VERTEX_W-1:0]  tail_vertex,
    input  wire logic [scc_pkg::VERTEX_W-1:0]  head_vertex,
    input  wire logic                          arc_present,
    input  wire logic                          last_arc,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [scc_pkg::VERTEX_W-1:0]       vertex_id,
    output logic [scc_pkg::COMP_W-1:0]         component_id,
    output logic                               last_result
);
    import scc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // The vertex count register may be written at any time; it is only
    // meaningful to change it between graphs.
    assign cfg_ready = 1'b1;

    // The controller sequences the loading of arcs, the forward pass that
    // records finish order, and the reverse pass that labels components.
    scc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last_arc (last_arc),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // The datapath holds the matrices, the walk stack, the finish order and
    // the output register, and performs one stack step per command.  The
    // output register lets the reverse pass continue with steps that emit no
    // result while a result beat waits to be taken.
    scc_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid),
        .cfg_data     (vertex_count),
        .tail_vertex  (tail_vertex),
        .head_vertex  (head_vertex),
        .arc_present  (arc_present),
        .cmd          (cmd),
        .sts          (sts),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .vertex_id    (vertex_id),
        .component_id (component_id),
        .last_result  (last_result)
    );

endmodule

`default_nettype wire

// ===== design/scc_checker.sv =====
`default_nettype none

module scc_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          last_arc,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic                          last_result
);

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat withdrawn while stalled");

    // Once the last arc is taken, arcs are refused while the run proceeds.
    a_run_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_arc |=> in_stall)
        else $error("arc accepted right after the last arc");

    // A new result appears only while arcs are refused.
    a_emit_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_stall)
        else $error("result produced while loading arcs");

    // Once loading reopens, only the final beat of the run can be pending.
    a_pending_last: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall && out_valid |-> last_result)
        else $error("non-final result pending while loading arcs");

endmodule

bind strongly_connected_components scc_checker u_scc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .last_arc    (last_arc),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .last_result (last_result)
);

`default_nettype wire
